// ===== rtl/dq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

  // Next-value source for one storage cell.
  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_LOAD,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_HEAD
  } sel_t;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] entry_value;
    logic [1:0]               status;
    logic                     last;
  } out_item_t;

endpackage

// ===== rtl/dq_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the queue chain: a value register and its source mux.
module dq_cell (
  input  logic                             clk,
  input  dq_pkg::sel_t                     sel,
  input  logic signed [dq_pkg::DATA_W-1:0] load_val,
  input  logic signed [dq_pkg::DATA_W-1:0] left_val,
  input  logic signed [dq_pkg::DATA_W-1:0] right_val,
  input  logic signed [dq_pkg::DATA_W-1:0] head_val,
  output logic signed [dq_pkg::DATA_W-1:0] val
);
  import dq_pkg::*;

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;

  always_comb begin
    unique case (sel)
      SEL_LOAD:  val_nxt = load_val;
      SEL_LEFT:  val_nxt = left_val;
      SEL_RIGHT: val_nxt = right_val;
      SEL_HEAD:  val_nxt = head_val;
      default:   val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Bounded double-ended queue built as a chain of shifting storage cells.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one command per
//   transaction: push front, push back, pop front, pop back or list.
//   Output channel (out_valid / out_stall / out_data) returns the results.
//   Entries sit packed in the chain with the front in cell 0; a push front
//   or pop front shifts the whole chain by one cell.
//   Push and pop give one result, in the cycle after acceptance, and a new
//   command is taken every cycle while the output register drains.
//   A list walks the chain: the head cell is emitted and the occupied cells
//   rotate by one, one result per cycle while the output register drains,
//   so the order is unchanged. The first entry is registered once the
//   state is ST_LIST; in_stall stays high until the last entry is emitted.
//   Reset (rst_n low, synchronous) empties the queue and the output
//   register; cell contents are not cleared.
//   When out_stall is high the pending result holds, and in_stall rises
//   until the output register is free again.
module double_ended_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dq_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dq_pkg::out_item_t out_data
);
  import dq_pkg::*;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         list_idx_r, list_idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;
  sel_t                     sel [DEPTH];
  logic signed [DATA_W-1:0] cell_q [DEPTH];

  logic out_free;
  logic in_take;
  logic full;
  logic empty;
  logic list_emit;
  logic list_last;
  cmd_t cmd;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cmd       = cmd_t'(in_data.command);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign list_emit = (state_r == ST_LIST) && out_free;
  assign list_last = ((CNT_W'(list_idx_r) + CNT_W'(1)) == count_r);

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = in_data.value;
    end else begin : g_mid_l
      assign left_v = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_q[i+1];
    end
    dq_cell u_cell (
      .clk       (clk),
      .sel       (sel[i]),
      .load_val  (in_data.value),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (cell_q[0]),
      .val       (cell_q[i])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take && (cmd == CMD_LIST) && !empty) begin
          state_nxt = ST_LIST;
        end
      end
      ST_LIST: begin
        if (list_emit && list_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and results
  always_comb begin
    count_nxt     = count_r;
    list_idx_nxt  = list_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    for (int i = 0; i < DEPTH; i++) begin
      sel[i] = SEL_HOLD;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.entry_value = '0;
          out_data_nxt.status      = STAT_OK;
          out_data_nxt.last        = 1'b1;
          list_idx_nxt             = '0;
          unique case (cmd)
            CMD_PUSH_FRONT: begin
              if (full) begin
                out_data_nxt.status = STAT_FULL;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  sel[i] = (i == 0) ? SEL_LOAD : SEL_LEFT;
                end
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                out_data_nxt.status = STAT_FULL;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (CNT_W'(i) == count_r) begin
                    sel[i] = SEL_LOAD;
                  end
                end
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                out_data_nxt.status = STAT_EMPTY;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  sel[i] = SEL_RIGHT;
                end
                count_nxt = count_r - CNT_W'(1);
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                out_data_nxt.status = STAT_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            CMD_LIST: begin
              // a non-empty list produces its results from ST_LIST
              if (empty) begin
                out_data_nxt.status = STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LIST: begin
        if (list_emit) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.entry_value = cell_q[0];
          out_data_nxt.status      = STAT_OK;
          out_data_nxt.last        = list_last;
          list_idx_nxt             = list_idx_r + IDX_W'(1);
          // rotate occupied cells: head goes to the back slot
          for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) + CNT_W'(1) == count_r) begin
              sel[i] = SEL_HEAD;
            end else if (CNT_W'(i) < count_r) begin
              sel[i] = SEL_RIGHT;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      list_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      list_idx_r  <= list_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_list_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST) |-> (count_r != '0) && (CNT_W'(list_idx_r) < count_r))
    else $error("list walk outside occupied cells");

  a_push_grows : assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && !full && ((cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK)))
    |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("accepted push did not grow the queue");

  a_list_holds_count : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST) |=> $stable(count_r))
    else $error("entry count changed during list");

endmodule
